>>> hdl/grcl_pkg.sv
// grcl_pkg: shared types and constants for the gain ramp, clip and level meter block
// used by grcl_front, grcl_scale, grcl_meter and gain_ramp_clip_level_meter_unit
`default_nettype none

package grcl_pkg;

    localparam logic [11:0] UNITY_GAIN      = 12'd1000;
    localparam logic [7:0]  RAMP_STEP_RESET = 8'd10;

    localparam logic [14:0] SAT_MAX = 15'd32767;
    // smallest product magnitude whose quotient by 1000 exceeds 32767
    localparam logic [27:0] SAT_LIM = 28'd32768000;

    // floor(x / 1000) == (x * RECIP_M) >> RECIP_SHIFT for x < SAT_LIM
    localparam int unsigned  RECIP_SHIFT = 35;
    localparam logic [25:0]  RECIP_M     = 26'd34359739;

    localparam int unsigned LEVEL_MAX = 100;

    // ceil(32767 * 10^((k-100)/50)) for k = 1..100, entry 0 unused
    localparam logic [14:0] LEVEL_THR [LEVEL_MAX+1] = '{
        15'd0,
        15'd344,   15'd360,   15'd377,   15'd394,   15'd413,
        15'd432,   15'd453,   15'd474,   15'd496,   15'd520,
        15'd544,   15'd570,   15'd597,   15'd625,   15'd654,
        15'd685,   15'd717,   15'd751,   15'd787,   15'd824,
        15'd862,   15'd903,   15'd946,   15'd990,   15'd1037,
        15'd1086,  15'd1137,  15'd1190,  15'd1246,  15'd1305,
        15'd1366,  15'd1431,  15'd1498,  15'd1569,  15'd1643,
        15'd1720,  15'd1801,  15'd1886,  15'd1975,  15'd2068,
        15'd2165,  15'd2267,  15'd2374,  15'd2486,  15'd2603,
        15'd2726,  15'd2854,  15'd2989,  15'd3130,  15'd3277,
        15'd3432,  15'd3593,  15'd3763,  15'd3940,  15'd4126,
        15'd4320,  15'd4524,  15'd4737,  15'd4960,  15'd5194,
        15'd5438,  15'd5695,  15'd5963,  15'd6244,  15'd6538,
        15'd6846,  15'd7169,  15'd7507,  15'd7861,  15'd8231,
        15'd8619,  15'd9025,  15'd9451,  15'd9896,  15'd10362,
        15'd10851, 15'd11362, 15'd11897, 15'd12458, 15'd13045,
        15'd13660, 15'd14304, 15'd14978, 15'd15684, 15'd16423,
        15'd17197, 15'd18007, 15'd18856, 15'd19745, 15'd20675,
        15'd21649, 15'd22670, 15'd23738, 15'd24857, 15'd26028,
        15'd27255, 15'd28539, 15'd29884, 15'd31293, 15'd32767
    };

    typedef struct packed {
        logic last;
        logic done;
        logic half;
    } side_t;

    typedef struct packed {
        logic [15:0] sample;
        logic [14:0] mag;
    } scale_res_t;

endpackage

`default_nettype wire

>>> hdl/grcl_front.sv
// grcl_front: first stage, gain ramp toward target and frame position counter
// depends on grcl_pkg
`default_nettype none

module grcl_front
    import grcl_pkg::*;
#(
    parameter int unsigned FRAME_PAIRS = 128
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire signed [15:0]  sample_in,
    input  wire        [11:0]  target_gain,
    input  wire                buffer_last,
    input  wire        [7:0]   ramp_step,
    output logic               out_valid,
    input  wire                out_ready,
    output logic signed [15:0] out_sample,
    output logic       [11:0]  out_gain,
    output side_t              out_side
);

    localparam int unsigned FRAME_LEN = 2 * FRAME_PAIRS;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);

    logic              valid_reg;
    logic [11:0]       gain_reg, gain_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              half_reg, half_next;
    logic              wrap;
    logic [12:0]       up_sum, dn_sum;
    logic              load;
    logic signed [15:0] sample_reg;
    logic [11:0]       gain_out_reg;
    side_t             side_reg;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        up_sum = {1'b0, gain_reg} + {5'd0, ramp_step};
        dn_sum = {1'b0, target_gain} + {5'd0, ramp_step};
        if (up_sum < {1'b0, target_gain}) begin
            gain_next = up_sum[11:0];
        end else if ({1'b0, gain_reg} > dn_sum) begin
            gain_next = gain_reg - {4'd0, ramp_step};
        end else begin
            gain_next = target_gain;
        end
        wrap      = (pos_reg == POS_W'(FRAME_LEN - 1));
        pos_next  = wrap ? '0 : pos_reg + POS_W'(1);
        half_next = half_reg ^ wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            gain_reg  <= UNITY_GAIN;
            pos_reg   <= '0;
            half_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load) begin
                gain_reg <= gain_next;
                pos_reg  <= pos_next;
                half_reg <= half_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sample_reg    <= sample_in;
            gain_out_reg  <= gain_next;
            side_reg.last <= buffer_last;
            side_reg.done <= wrap;
            side_reg.half <= half_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;
    assign out_gain   = gain_out_reg;
    assign out_side   = side_reg;

endmodule

`default_nettype wire

>>> hdl/grcl_scale.sv
// grcl_scale: two stages, gain multiply then divide by 1000 with saturation
// depends on grcl_pkg
`default_nettype none

module grcl_scale
    import grcl_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire signed [15:0] in_sample,
    input  wire       [11:0]  in_gain,
    input  side_t             in_side,
    output logic              out_valid,
    input  wire               out_ready,
    output scale_res_t        out_res,
    output side_t             out_side
);

    logic               v2_reg, v3_reg;
    logic               rdy2, rdy3;
    logic               load2, load3;
    logic signed [28:0] prod_next, prod_reg;
    side_t              side2_reg, side3_reg;
    logic [27:0]        abs_prod;
    logic               sat_next, sat_reg;
    logic               neg_reg;
    logic [50:0]        recip_prod;
    logic [14:0]        quot_reg;
    logic [14:0]        mag;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;
    assign load2    = in_valid && rdy2;
    assign load3    = v2_reg && rdy3;

    always_comb begin
        prod_next  = 29'(in_sample) * 29'($signed({1'b0, in_gain}));
        abs_prod   = prod_reg[28] ? 28'(-prod_reg) : prod_reg[27:0];
        sat_next   = abs_prod >= SAT_LIM;
        recip_prod = 51'(abs_prod[24:0]) * 51'(RECIP_M);
        mag        = sat_reg ? SAT_MAX : quot_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy2) begin
                v2_reg <= in_valid;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            prod_reg  <= prod_next;
            side2_reg <= in_side;
        end
        if (load3) begin
            neg_reg   <= prod_reg[28];
            sat_reg   <= sat_next;
            quot_reg  <= recip_prod[RECIP_SHIFT +: 15];
            side3_reg <= side2_reg;
        end
    end

    assign out_valid      = v3_reg;
    assign out_res.mag    = mag;
    assign out_res.sample = neg_reg ? 16'd0 - {1'b0, mag} : {1'b0, mag};
    assign out_side       = side3_reg;

endmodule

`default_nettype wire

>>> hdl/grcl_meter.sv
// grcl_meter: peak tracking, threshold level lookup, smoothing and output register
// depends on grcl_pkg
`default_nettype none

module grcl_meter
    import grcl_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          in_valid,
    output logic         in_ready,
    input  scale_res_t   in_res,
    input  side_t        in_side,
    output logic         out_valid,
    input  wire          out_ready,
    output logic [15:0]  sample_out,
    output logic         frame_done,
    output logic         fill_half,
    output logic [6:0]   level_out
);

    logic        v4_reg, v5_reg, v6_reg;
    logic        rdy4, rdy5, rdy6;
    logic        load4, load5, load6;
    logic [14:0] peak_reg, peak_max;
    logic [14:0] pk_reg;
    logic [15:0] samp4_reg, samp5_reg, samp6_reg;
    side_t       side4_reg, side5_reg, side6_reg;
    logic [6:0]  lvl_next, lvl_reg;
    logic [6:0]  smooth_reg, smooth_next;
    logic [9:0]  decay_sum;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;
    assign load4    = in_valid && rdy4;
    assign load5    = v4_reg && rdy5;
    assign load6    = v5_reg && rdy6;

    always_comb begin
        peak_max = (in_res.mag > peak_reg) ? in_res.mag : peak_reg;
        lvl_next = '0;
        for (int k = 1; k <= LEVEL_MAX; k++) begin
            if (pk_reg >= LEVEL_THR[k]) begin
                lvl_next = 7'(k);
            end
        end
        decay_sum = 10'(smooth_reg) * 10'd7 + 10'(lvl_reg);
        if (!side5_reg.last) begin
            smooth_next = smooth_reg;
        end else if (lvl_reg > smooth_reg) begin
            smooth_next = lvl_reg;
        end else begin
            smooth_next = decay_sum[9:3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
            v6_reg     <= 1'b0;
            peak_reg   <= '0;
            smooth_reg <= '0;
        end else begin
            if (rdy4) begin
                v4_reg <= in_valid;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
            if (load4) begin
                peak_reg <= in_side.last ? '0 : peak_max;
            end
            if (load6) begin
                smooth_reg <= smooth_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load4) begin
            pk_reg    <= peak_max;
            samp4_reg <= in_res.sample;
            side4_reg <= in_side;
        end
        if (load5) begin
            lvl_reg   <= lvl_next;
            samp5_reg <= samp4_reg;
            side5_reg <= side4_reg;
        end
        if (load6) begin
            samp6_reg <= samp5_reg;
            side6_reg <= side5_reg;
        end
    end

    assign out_valid  = v6_reg;
    assign sample_out = samp6_reg;
    assign frame_done = side6_reg.done;
    assign fill_half  = side6_reg.half;
    assign level_out  = smooth_reg;

endmodule

`default_nettype wire

>>> hdl/gain_ramp_clip_level_meter_unit.sv
// gain_ramp_clip_level_meter_unit: digital volume with gain ramp, clip and peak level meter
// depends on grcl_pkg, grcl_front, grcl_scale, grcl_meter
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------------------
//  s_       | s_tvalid/s_tready | tdata: sample_in[15:0], target_gain[27:16]; tlast: buffer_last
//  m_       | m_tvalid/m_tready | tdata: sample_out[15:0], level_out[22:16]; tlast: frame_done;
//           |                   | tuser: fill_half
//  cfg_     | cfg_valid/ready   | cfg_data: ramp_step
//
//  one beat per cycle sustained while m_tready stays high
//  six register stages: gain ramp, multiply, reciprocal divide, peak, level, smoothing
//  each stage holds only while it is full and the stage after it is stalled,
//  so empty stages keep taking beats while a result waits on m_tready
//  synchronous active-low reset clears all stages, gain to unity, ramp_step to 10
`default_nettype none

module gain_ramp_clip_level_meter_unit
    import grcl_pkg::*;
#(
    parameter int unsigned FRAME_PAIRS = 128
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // sample_in[15:0], target_gain[27:16], zero[31:28]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // sample_out[15:0], level_out[22:16], zero[23]
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // fill_half[0]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_data
);

    logic [7:0]         ramp_step_reg;
    logic               f_valid, f_ready;
    logic signed [15:0] f_sample;
    logic [11:0]        f_gain;
    side_t              f_side;
    logic               c_valid, c_ready;
    scale_res_t         c_res;
    side_t              c_side;
    logic [15:0]        sample_out;
    logic               frame_done, fill_half;
    logic [6:0]         level_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_step_reg <= RAMP_STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            ramp_step_reg <= cfg_data;
        end
    end

    grcl_front #(
        .FRAME_PAIRS(FRAME_PAIRS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .sample_in   ($signed(s_tdata[15:0])),
        .target_gain (s_tdata[27:16]),
        .buffer_last (s_tlast),
        .ramp_step   (ramp_step_reg),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_sample  (f_sample),
        .out_gain    (f_gain),
        .out_side    (f_side)
    );

    grcl_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_sample (f_sample),
        .in_gain   (f_gain),
        .in_side   (f_side),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_res   (c_res),
        .out_side  (c_side)
    );

    grcl_meter u_meter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (c_valid),
        .in_ready   (c_ready),
        .in_res     (c_res),
        .in_side    (c_side),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .sample_out (sample_out),
        .frame_done (frame_done),
        .fill_half  (fill_half),
        .level_out  (level_out)
    );

    assign m_tdata = {1'b0, level_out, sample_out};
    assign m_tlast = frame_done;
    assign m_tuser = fill_half;

    // input only backs up when the output beat is stuck
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output beat pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[22:16] <= 7'd100)
        else $error("level above full scale");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] != 16'h8000)
        else $error("sample not saturated to symmetric range");

    // an item entering with an empty, unstalled pipeline leaves it after passing through every stage register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !f_valid && !c_valid && !m_tvalid && m_tready)
            |=> ##5 m_tvalid)
        else $error("pipeline latency broken");

endmodule

`default_nettype wire
